@@ hdl/dhg_pkg.sv @@
// ----------------------------------------------------------------------------
// Double-height glyph renderer package
// Shared sizes, microcode format, the microcode program and the code mapping.
// ----------------------------------------------------------------------------
package dhg_pkg;

  localparam int LINE_WIDTH   = 128;
  localparam int FONT_ENTRIES = 128;

  localparam int GLYPH_W    = $clog2(FONT_ENTRIES);
  localparam int FONT_AW    = GLYPH_W + 3;
  localparam int FONT_DEPTH = FONT_ENTRIES * 8;
  localparam int ROW_W      = 6;
  localparam int FB_AW      = 10;
  localparam int PC_W       = 3;

  localparam logic [2:0] LAST_ROW = 3'd7;
  localparam logic [2:0] LAST_COL = 3'd5;

  localparam logic [7:0] CODE_BLOCK     = 8'hFF;
  localparam logic [7:0] CODE_FIRST     = 8'h20;
  localparam logic [7:0] CODE_LAST      = 8'h7F;
  localparam int         GLYPH_BLOCK    = 96;
  localparam logic [15:0] INVERT_MASK   = 16'h3FFF;
  localparam int         CELL_MARGIN    = 4;

  typedef enum logic [1:0] {
    OP_NOP  = 2'd0,
    OP_READ = 2'd1,
    OP_EMIT = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    J_WAIT   = 3'd0,  // hold until a draw starts
    J_NEXT   = 3'd1,  // fall through
    J_ROWS   = 3'd2,  // repeat until the last font row is read
    J_COL_SD = 3'd3,  // single width: close the column, else fall through
    J_COL    = 3'd4   // close the column
  } jmp_e;

  typedef struct packed {
    op_e              op;
    logic             hi;
    logic             dup;
    jmp_e             jmp;
    logic [PC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    op_e        op;
    logic       hi;
    logic       dup;
    logic       last;
    logic [2:0] row;
    logic [2:0] col;
  } ctrl_t;

  typedef struct packed {
    logic dw;
    logic out_free;
  } stat_t;

  localparam logic [PC_W-1:0] PC_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] PC_READ  = 3'd1;
  localparam logic [PC_W-1:0] PC_EMIT  = 3'd3;
  localparam logic [PC_W-1:0] PC_MAX   = 3'd6;

  // The microcode program: read eight font rows, then per column emit the
  // low and high bytes and, in double width, their duplicates.
  function automatic uword_t ucode_rom(logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, hi: 1'b0, dup: 1'b0, jmp: J_NEXT, target: PC_IDLE};
    unique case (pc)
      3'd0: w = '{op: OP_NOP,  hi: 1'b0, dup: 1'b0, jmp: J_WAIT,   target: PC_READ};
      3'd1: w = '{op: OP_READ, hi: 1'b0, dup: 1'b0, jmp: J_ROWS,   target: PC_IDLE};
      3'd2: w = '{op: OP_NOP,  hi: 1'b0, dup: 1'b0, jmp: J_NEXT,   target: PC_IDLE};
      3'd3: w = '{op: OP_EMIT, hi: 1'b0, dup: 1'b0, jmp: J_NEXT,   target: PC_IDLE};
      3'd4: w = '{op: OP_EMIT, hi: 1'b1, dup: 1'b0, jmp: J_COL_SD, target: PC_EMIT};
      3'd5: w = '{op: OP_EMIT, hi: 1'b0, dup: 1'b1, jmp: J_NEXT,   target: PC_IDLE};
      3'd6: w = '{op: OP_EMIT, hi: 1'b1, dup: 1'b1, jmp: J_COL,    target: PC_EMIT};
      default: w = '{op: OP_NOP, hi: 1'b0, dup: 1'b0, jmp: J_NEXT, target: PC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [GLYPH_W-1:0] glyph_map(logic [7:0] code);
    logic [GLYPH_W-1:0] g;
    g = '0;
    if (code == CODE_BLOCK) begin
      g = GLYPH_W'(GLYPH_BLOCK);
    end else if (code >= CODE_FIRST && code <= CODE_LAST) begin
      g = GLYPH_W'(code - CODE_FIRST);
    end
    return g;
  endfunction

endpackage

@@ hdl/double_height_text_glyph_renderer.sv @@
// ----------------------------------------------------------------------------
// Double-height text glyph renderer
// Loads 6x8 font rows and renders a character as framebuffer byte writes.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                  Transfer moves
//   in       input      in_valid_i / in_stall_o    one load row or one draw
//   out      output     out_valid_o / out_stall_i  one framebuffer byte write
//
// A load writes one font row. A draw reads the eight font rows through the
// single memory read port, waits for the last read to land, then makes
// one write per cycle while the output is not stalled: 12 writes, or 24
// in double width.
// Reset clears the sequencer and the output valid; the font memory keeps
// whatever it holds and must be loaded before it is drawn from.
// The input is stalled while a draw is in progress; a new item is taken as
// soon as the last write sits in the output register.
module double_height_text_glyph_renderer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mode_i,
  input  logic [6:0]                 glyph_index_i,
  input  logic [2:0]                 glyph_row_i,
  input  logic [5:0]                 row_bits_i,
  input  logic [7:0]                 character_i,
  input  logic [4:0]                 col_pos_i,
  input  logic [1:0]                 row_pos_i,
  input  logic                       inverted_i,
  input  logic                       double_width_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [9:0]                 fb_address_o,
  output logic [7:0]                 fb_data_o,
  output logic                       last_o
);
  import dhg_pkg::*;

  logic               idle;
  logic               accept;
  logic               start;
  logic [8:0]         gi_ext;
  logic               font_we;
  logic [FONT_AW-1:0] font_waddr;
  logic               ram_re;
  logic [FONT_AW-1:0] ram_raddr;
  logic [ROW_W-1:0]   ram_rdata;
  ctrl_t              ctrl;
  stat_t              stat;

  assign in_stall_o = !idle;
  assign accept     = in_valid_i && !in_stall_o;
  assign start      = accept && mode_i;

  // Loads beyond the font size are dropped.
  assign gi_ext     = 9'(glyph_index_i);
  assign font_we    = accept && !mode_i && (gi_ext < 9'(FONT_ENTRIES));
  assign font_waddr = {gi_ext[GLYPH_W-1:0], glyph_row_i};

  dhg_font_ram u_font_ram (
    .clk_i   (clk_i),
    .we_i    (font_we),
    .waddr_i (font_waddr),
    .wdata_i (row_bits_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dhg_sequencer u_sequencer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .idle_o  (idle)
  );

  dhg_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .character_i    (character_i),
    .col_pos_i      (col_pos_i),
    .row_pos_i      (row_pos_i),
    .inverted_i     (inverted_i),
    .double_width_i (double_width_i),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fb_address_o   (fb_address_o),
    .fb_data_o      (fb_data_o),
    .last_o         (last_o)
  );

endmodule

@@ hdl/dhg_font_ram.sv @@
// ----------------------------------------------------------------------------
// Font row memory
// One write port for font loads and one registered read port for drawing.
// ----------------------------------------------------------------------------
module dhg_font_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [dhg_pkg::FONT_AW-1:0]  waddr_i,
  input  logic [dhg_pkg::ROW_W-1:0]    wdata_i,
  input  logic                         re_i,
  input  logic [dhg_pkg::FONT_AW-1:0]  raddr_i,
  output logic [dhg_pkg::ROW_W-1:0]    rdata_o
);
  import dhg_pkg::*;

  logic [ROW_W-1:0] mem_q [FONT_DEPTH];
  logic [ROW_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/dhg_sequencer.sv @@
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over the microcode program with row and column loop counters.
// ----------------------------------------------------------------------------
module dhg_sequencer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  dhg_pkg::stat_t         stat_i,
  output dhg_pkg::ctrl_t         ctrl_o,
  output logic                   idle_o
);
  import dhg_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  logic [2:0]      row_q, row_d;
  logic [2:0]      col_q, col_d;
  uword_t          uw;
  logic            adv;
  logic            last;

  assign uw   = ucode_rom(pc_q);
  // Emit steps wait for room in the output register.
  assign adv  = (uw.op != OP_EMIT) || stat_i.out_free;
  assign last = (uw.jmp == J_COL || (uw.jmp == J_COL_SD && !stat_i.dw)) &&
                (col_q == LAST_COL);

  always_comb begin
    pc_d  = pc_q;
    row_d = row_q;
    col_d = col_q;
    if (adv) begin
      unique case (uw.jmp)
        J_WAIT: begin
          if (start_i) begin
            pc_d  = uw.target;
            row_d = '0;
            col_d = '0;
          end
        end
        J_NEXT: begin
          pc_d = pc_q + 1'b1;
        end
        J_ROWS: begin
          if (row_q == LAST_ROW) begin
            pc_d = pc_q + 1'b1;
          end else begin
            row_d = row_q + 1'b1;
          end
        end
        J_COL_SD, J_COL: begin
          if (uw.jmp == J_COL_SD && stat_i.dw) begin
            pc_d = pc_q + 1'b1;
          end else if (col_q == LAST_COL) begin
            pc_d = PC_IDLE;
          end else begin
            col_d = col_q + 1'b1;
            pc_d  = uw.target;
          end
        end
        default: pc_d = PC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= PC_IDLE;
      row_q <= '0;
      col_q <= '0;
    end else begin
      pc_q  <= pc_d;
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  assign ctrl_o = '{op: uw.op, hi: uw.hi, dup: uw.dup, last: last,
                    row: row_q, col: col_q};
  assign idle_o = (uw.jmp == J_WAIT);

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PC_MAX)
    else $error("step counter left the program");

  a_start_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idle_o && start_i) |=> (pc_q == PC_READ && row_q == 3'd0 && col_q == 3'd0))
    else $error("draw did not start at the first read step");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == OP_EMIT && last && adv) |=> (pc_q == PC_IDLE))
    else $error("final write did not return the sequencer to idle");

endmodule

@@ hdl/dhg_datapath.sv @@
// ----------------------------------------------------------------------------
// Glyph datapath
// Holds the draw item, gathers eight font rows, builds columns and addresses,
// and owns the output register.
// ----------------------------------------------------------------------------
module dhg_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [7:0]                    character_i,
  input  logic [4:0]                    col_pos_i,
  input  logic [1:0]                    row_pos_i,
  input  logic                          inverted_i,
  input  logic                          double_width_i,
  input  dhg_pkg::ctrl_t                ctrl_i,
  output dhg_pkg::stat_t                stat_o,
  output logic                          ram_re_o,
  output logic [dhg_pkg::FONT_AW-1:0]   ram_raddr_o,
  input  logic [dhg_pkg::ROW_W-1:0]     ram_rdata_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dhg_pkg::FB_AW-1:0]     fb_address_o,
  output logic [7:0]                    fb_data_o,
  output logic                          last_o
);
  import dhg_pkg::*;

  localparam logic [FB_AW-1:0] LINE_FB  = FB_AW'(LINE_WIDTH);
  localparam logic [FB_AW-1:0] PAGE2_FB = FB_AW'(2 * LINE_WIDTH);
  localparam logic [FB_AW-1:0] MARGIN   = FB_AW'(CELL_MARGIN);

  logic [GLYPH_W-1:0] glyph_q;
  logic [FB_AW-1:0]   base_q, base_d;
  logic               inv_q, dw_q;
  logic               rd_pend_q;
  logic [2:0]         rd_row_q;
  logic [ROW_W-1:0]   rows_q [8];

  logic [FB_AW-1:0]   cx;
  logic [FB_AW-1:0]   cell_off;
  logic [2:0]         bit_sel;
  logic [15:0]        dbl;
  logic [15:0]        shifted;
  logic [FB_AW-1:0]   col_off;
  logic [FB_AW-1:0]   addr;
  logic               out_free;
  logic               load;

  logic               out_valid_q;
  logic [FB_AW-1:0]   addr_q;
  logic [7:0]         data_q;
  logic               last_q;

  // Cell origin: two pages per text row, 6 or 12 pixels per text column.
  always_comb begin
    cx = FB_AW'(col_pos_i);
    if (double_width_i) begin
      cell_off = (cx << 3) + (cx << 2);
    end else begin
      cell_off = (cx << 2) + (cx << 1);
    end
    base_d = FB_AW'(FB_AW'(row_pos_i) * PAGE2_FB) + cell_off + MARGIN;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      glyph_q <= glyph_map(character_i);
      base_q  <= base_d;
      inv_q   <= inverted_i;
      dw_q    <= double_width_i;
    end
  end

  assign ram_re_o    = (ctrl_i.op == OP_READ);
  assign ram_raddr_o = {glyph_q, ctrl_i.row};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= ram_re_o;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_row_q <= ctrl_i.row;
    if (rd_pend_q) begin
      rows_q[rd_row_q] <= ram_rdata_i;
    end
  end

  // Column bits come from the six-bit rows, leftmost pixel in bit 5; each
  // pixel is doubled vertically.
  always_comb begin
    bit_sel = LAST_COL - ctrl_i.col;
    for (int r = 0; r < 8; r++) begin
      dbl[2*r]   = rows_q[r][bit_sel];
      dbl[2*r+1] = rows_q[r][bit_sel];
    end
    if (inv_q && ctrl_i.col != 3'd0) begin
      dbl = dbl ^ INVERT_MASK;
    end
    shifted = {dbl[13:0], 2'b00};
  end

  always_comb begin
    col_off = dw_q ? FB_AW'({ctrl_i.col, 1'b0}) : FB_AW'(ctrl_i.col);
    addr    = base_q + col_off + (ctrl_i.hi ? LINE_FB : '0) +
              (ctrl_i.dup ? FB_AW'(1) : '0);
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = (ctrl_i.op == OP_EMIT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      addr_q <= addr;
      data_q <= ctrl_i.hi ? shifted[15:8] : shifted[7:0];
      last_q <= ctrl_i.last;
    end
  end

  assign stat_o       = '{dw: dw_q, out_free: out_free};
  assign out_valid_o  = out_valid_q;
  assign fb_address_o = addr_q;
  assign fb_data_o    = data_q;
  assign last_o       = last_q;

  a_read_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re_o |=> rd_pend_q)
    else $error("font read was not followed by a capture");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("emitted write did not reach the output register");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=>
      (out_valid_q && $stable(addr_q) && $stable(data_q) && $stable(last_q)))
    else $error("stalled write changed before its transfer");

endmodule

@@ verif/double_height_text_glyph_renderer_tb.sv @@
// ----------------------------------------------------------------------------
// Double-height text glyph renderer testbench
// Loads font rows and draws characters through the valid/stall channels.
// Every framebuffer write is checked against a local model of the font
// memory and the column rendering. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module double_height_text_glyph_renderer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dhg_pkg::*;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  localparam logic [7:0]  CHAR_BLOCK  = 8'hFF;
  localparam logic [7:0]  CHAR_FIRST  = 8'h20;
  localparam logic [7:0]  CHAR_LAST   = 8'h7F;
  localparam int          BLOCK_GLYPH = 96;
  localparam logic [15:0] FLIP_MASK   = 16'h3FFF;
  localparam int          LEFT_MARGIN = 4;

  localparam int ITEM_TARGET = 430;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 200;
  localparam int IDLE_LIMIT  = 1000;
  localparam int TAIL_CYCLES = 50;

  typedef struct packed {
    logic       mode;
    logic [6:0] glyph_index;
    logic [2:0] glyph_row;
    logic [5:0] row_bits;
    logic [7:0] character;
    logic [4:0] col_pos;
    logic [1:0] row_pos;
    logic       inverted;
    logic       double_width;
    logic       drain;
  } cmd_t;

  typedef struct packed {
    logic [9:0] addr;
    logic [7:0] data;
    logic       last;
  } fb_write_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  cmd_t cur_cmd = '0;

  logic       in_stall_o;
  logic       out_valid_o;
  logic [9:0] fb_address_o;
  logic [7:0] fb_data_o;
  logic       last_o;

  cmd_t      cmds_to_send[$];
  fb_write_t writes_due[$];
  logic [5:0] font_mem [FONT_DEPTH];
  logic [7:0] rows_loaded [FONT_ENTRIES];
  logic      drain_req = 1'b0;

  int gap_left, calm_in, stall_left, calm_out, idle_cycles;
  int err_cnt, loads_done, draws_done, dw_draws, inv_draws, writes_seen;

  always #5 clk_i = ~clk_i;

  double_height_text_glyph_renderer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (cur_cmd.mode),
    .glyph_index_i  (cur_cmd.glyph_index),
    .glyph_row_i    (cur_cmd.glyph_row),
    .row_bits_i     (cur_cmd.row_bits),
    .character_i    (cur_cmd.character),
    .col_pos_i      (cur_cmd.col_pos),
    .row_pos_i      (cur_cmd.row_pos),
    .inverted_i     (cur_cmd.inverted),
    .double_width_i (cur_cmd.double_width),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fb_address_o   (fb_address_o),
    .fb_data_o      (fb_data_o),
    .last_o         (last_o)
  );

  function automatic int glyph_for_code(logic [7:0] code);
    if (code == CHAR_BLOCK) return BLOCK_GLYPH;
    if (code >= CHAR_FIRST && code <= CHAR_LAST) return int'(code - CHAR_FIRST);
    return 0;
  endfunction

  function automatic void add_write(int addr, logic [7:0] data, logic last);
    fb_write_t w;
    w.addr = addr[9:0];
    w.data = data;
    w.last = last;
    writes_due.push_back(w);
  endfunction

  // Expected byte writes of one draw, in the order the block emits them.
  function automatic void render_char(cmd_t c);
    int glyph, base, off, r, col;
    logic [15:0] column;
    logic        px;
    glyph = glyph_for_code(c.character);
    base = int'(c.row_pos) * 2 * LINE_WIDTH
         + int'(c.col_pos) * (c.double_width ? 12 : 6) + LEFT_MARGIN;
    for (col = 0; col < 6; col++) begin
      column = '0;
      for (r = 0; r < 8; r++) begin
        px = font_mem[glyph * 8 + r][5 - col];
        column[2 * r]     = px;
        column[2 * r + 1] = px;
      end
      if (col > 0 && c.inverted) column = column ^ FLIP_MASK;
      column = column << 2;
      off = base + (c.double_width ? 2 * col : col);
      add_write(off, column[7:0], 1'b0);
      add_write(off + LINE_WIDTH, column[15:8], col == 5 && !c.double_width);
      if (c.double_width) begin
        add_write(off + 1, column[7:0], 1'b0);
        add_write(off + LINE_WIDTH + 1, column[15:8], col == 5);
      end
    end
  endfunction

  function automatic void take_cmd(cmd_t c);
    if (c.mode == MODE_LOAD) begin
      if (int'(c.glyph_index) < FONT_ENTRIES)
        font_mem[c.glyph_index * 8 + c.glyph_row] = c.row_bits;
      loads_done++;
    end else begin
      render_char(c);
      draws_done++;
      if (c.double_width) dw_draws++;
      if (c.inverted) inv_draws++;
    end
  endfunction

  function automatic void push_cmd(cmd_t c);
    c.drain = drain_req;
    drain_req = 1'b0;
    cmds_to_send.push_back(c);
  endfunction

  function automatic void queue_load(int gi, int gr, int bits);
    cmd_t c;
    c = '0;
    c.mode = MODE_LOAD;
    c.glyph_index = gi[6:0];
    c.glyph_row = gr[2:0];
    c.row_bits = bits[5:0];
    // Scramble the draw-only fields; a load must not look at them.
    c.character = 8'($urandom);
    c.col_pos = 5'($urandom);
    c.row_pos = 2'($urandom);
    c.inverted = 1'($urandom);
    c.double_width = 1'($urandom);
    rows_loaded[gi][gr] = 1'b1;
    push_cmd(c);
  endfunction

  function automatic void queue_draw(logic [7:0] code, int cx, int cy, bit inv, bit dw);
    cmd_t c;
    c = '0;
    c.mode = MODE_DRAW;
    c.glyph_index = 7'($urandom);
    c.glyph_row = 3'($urandom);
    c.row_bits = 6'($urandom);
    c.character = code;
    c.col_pos = cx[4:0];
    c.row_pos = cy[1:0];
    c.inverted = inv;
    c.double_width = dw;
    push_cmd(c);
  endfunction

  // Sender: presents queued items, with random gaps after each transfer.
  always @(posedge clk_i or negedge rst_ni) begin : sender
    int   g;
    logic sending;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left <= 0;
      calm_in <= 0;
    end else begin
      g = gap_left;
      sending = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        take_cmd(cur_cmd);
        sending = 1'b0;
        if (calm_in > 0) begin
          g = 0;
          calm_in <= calm_in - 1;
        end else if ($urandom_range(0, 15) == 0) begin
          g = 0;
          calm_in <= $urandom_range(10, 40);
        end else begin
          g = $urandom_range(0, 9);
        end
      end
      if (!sending) begin
        if (g > 0) begin
          g--;
        end else if (cmds_to_send.size() != 0 &&
                     !(cmds_to_send[0].drain && writes_due.size() != 0)) begin
          cur_cmd <= cmds_to_send.pop_front();
          sending = 1'b1;
        end
      end
      in_valid_i <= sending;
      gap_left <= g;
    end
  end

  // Receiver: checks each write transfer and stalls at random afterwards.
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    int        s;
    fb_write_t w;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
      calm_out <= 0;
    end else begin
      s = stall_left;
      if (out_valid_o && !out_stall_i) begin
        writes_seen++;
        if (writes_due.size() == 0) begin
          $error("framebuffer write %0h <= %0h with nothing expected", fb_address_o, fb_data_o);
          err_cnt++;
        end else begin
          w = writes_due.pop_front();
          if (fb_address_o !== w.addr) begin
            $error("fb_address: expected %0d, got %0d", w.addr, fb_address_o);
            err_cnt++;
          end
          if (fb_data_o !== w.data) begin
            $error("fb_data: expected %0h, got %0h", w.data, fb_data_o);
            err_cnt++;
          end
          if (last_o !== w.last) begin
            $error("last: expected %0b, got %0b", w.last, last_o);
            err_cnt++;
          end
        end
        // One long hold-off lets the block fill up and stall its input.
        if (writes_seen == HOLD_AT) begin
          s = HOLD_CYCLES;
        end else if (calm_out > 0) begin
          s = 0;
          calm_out <= calm_out - 1;
        end else if ($urandom_range(0, 15) == 0) begin
          s = 0;
          calm_out <= $urandom_range(20, 80);
        end else begin
          s = $urandom_range(0, 9);
        end
      end
      if (s > 0) begin
        out_stall_i <= 1'b1;
        s--;
      end else begin
        out_stall_i <= 1'b0;
      end
      stall_left <= s;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int   i, r, g, tries;
    logic [7:0] code;
    bit   timed_out;

    for (i = 0; i < FONT_ENTRIES; i++) rows_loaded[i] = '0;

    // Directed part: the space and block glyphs, the top font entry, then
    // draws over the code mapping edges and the position extremes.
    queue_load(0, 0, 6'h00);
    queue_load(0, 1, 6'h21);
    queue_load(0, 2, 6'h12);
    queue_load(0, 3, 6'h0C);
    queue_load(0, 4, 6'h3F);
    queue_load(0, 5, 6'h2A);
    queue_load(0, 6, 6'h15);
    queue_load(0, 7, 6'h00);
    for (r = 0; r < 8; r++) queue_load(BLOCK_GLYPH, r, (r == 3) ? 6'h00 : 6'h3F);
    queue_load(127, 7, 6'h3F);
    queue_draw(8'hFF, 0, 0, 1'b0, 1'b0);
    queue_draw(8'hFF, 31, 3, 1'b1, 1'b1);
    queue_draw(8'h20, 19, 3, 1'b1, 1'b0);
    queue_draw(8'h00, 0, 0, 1'b0, 1'b1);
    queue_draw(8'h1F, 20, 1, 1'b1, 1'b0);
    queue_draw(8'h80, 5, 2, 1'b0, 1'b1);
    queue_draw(8'hFE, 31, 0, 1'b1, 1'b1);

    // Random part: mostly whole glyph loads followed by draws of loaded
    // glyphs, with stray single-row loads mixed in.
    drain_req = 1'b1;
    while (cmds_to_send.size() < ITEM_TARGET) begin
      if (cmds_to_send.size() >= 200 && cmds_to_send.size() < 205) drain_req = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 15) begin
        g = $urandom_range(0, BLOCK_GLYPH);
        for (i = 0; i < 8; i++) queue_load(g, i, $urandom_range(0, 63));
      end else if (r < 38) begin
        queue_load($urandom_range(0, 127), $urandom_range(0, 7), $urandom_range(0, 63));
      end else begin
        code = 8'($urandom_range(0, 255));
        for (tries = 0; tries < 6 && rows_loaded[glyph_for_code(code)] != 8'hFF; tries++)
          code = 8'($urandom_range(0, 255));
        if (rows_loaded[glyph_for_code(code)] != 8'hFF) code = 8'($urandom_range(0, 31));
        queue_draw(code, ($urandom_range(0, 4) == 0) ? $urandom_range(20, 31)
                                                     : $urandom_range(0, 19),
                   $urandom_range(0, 3), 1'($urandom), 1'($urandom));
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    timed_out = 1'b0;
    while (!timed_out && (cmds_to_send.size() != 0 || in_valid_i || writes_due.size() != 0)) begin
      @(posedge clk_i);
      timed_out = idle_cycles >= IDLE_LIMIT;
    end
    if (timed_out) begin
      $error("no transfer for %0d cycles, %0d writes outstanding", IDLE_LIMIT, writes_due.size());
      err_cnt++;
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk_i);
      if (writes_due.size() != 0) begin
        $error("%0d framebuffer writes never arrived", writes_due.size());
        err_cnt++;
      end
    end

    $display("Covered %0d font row loads and %0d draws (%0d double width, %0d inverted),",
             loads_done, draws_done, dw_draws, inv_draws);
    $display("with %0d framebuffer writes checked and %0d errors.", writes_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("double_height_text_glyph_renderer_tb: done, clean");
    end else begin
      $display("double_height_text_glyph_renderer_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/dhg_pkg.sv
hdl/dhg_font_ram.sv
hdl/dhg_sequencer.sv
hdl/dhg_datapath.sv
hdl/double_height_text_glyph_renderer.sv
verif/double_height_text_glyph_renderer_tb.sv
